// ----- rtl/core/aeba_pkg.sv -----
// Shared constants, codes and types for the audio envelope bar averager.
`default_nettype none
package aeba_pkg;

    // Fixed field widths.
    localparam int SUM_W      = 32;
    localparam int LEVEL_W    = 8;
    localparam int CHAN_W     = 3;
    localparam int BARIDX_W   = 9;
    localparam int FPB_W      = 16;
    localparam int NCH_CFG_W  = 4;
    localparam int NCH_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Level scaling: mean magnitude over full scale times 2^LEVEL_SHIFT.
    localparam int LEVEL_SHIFT = 9;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_BAR = 1'd1;

    // Parameter defaults.
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_BAR_COUNT    = 512;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int QUEUE_DEPTH      = 2;

    // Per-bar header that travels with the channel sums to the divider.
    typedef struct packed {
        logic [FPB_W-1:0]    fpb;
        logic [NCH_W-1:0]    nch;
        logic [BARIDX_W-1:0] bar;
    } t_bar_hdr;

endpackage
`default_nettype wire

// ----- rtl/core/aeba_front.sv -----
// Front end: takes samples, accumulates per-channel magnitudes, queues finished bars.
`default_nettype none
module aeba_front #(
    parameter int MAX_CHANNELS = aeba_pkg::DEF_MAX_CHANNELS,
    parameter int BAR_COUNT    = aeba_pkg::DEF_BAR_COUNT,
    parameter int SAMPLE_BITS  = aeba_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_sample_valid,
    output logic                                           o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]                  i_sample,
    input  logic [aeba_pkg::NCH_CFG_W-1:0]                 i_num_channels,
    input  logic [aeba_pkg::FPB_W-1:0]                     i_frames_per_bar,
    input  logic                                           i_full,
    output logic                                           o_push,
    output logic [MAX_CHANNELS-1:0][aeba_pkg::SUM_W-1:0]   o_push_sums,
    output aeba_pkg::t_bar_hdr                             o_push_hdr
);
    import aeba_pkg::*;

    localparam int POS_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int BC_W  = $clog2(BAR_COUNT + 1);
    localparam int MAG_W = SAMPLE_BITS + 1;

    logic [MAX_CHANNELS-1:0][SUM_W-1:0] r_sums, n_sums;
    logic [POS_W-1:0]                   r_pos, n_pos;
    logic [FPB_W-1:0]                   r_frame, n_frame;
    logic [BC_W-1:0]                    r_bar, n_bar;

    logic [NCH_W-1:0] nch_eff;
    logic [FPB_W-1:0] fpb_eff;
    logic [MAG_W-1:0] ext, mag;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_new;
    logic             frame_end, bar_end, done, accept;

    always_comb begin
        if (i_num_channels == '0) begin
            nch_eff = NCH_W'(1);
        end else if (NCH_W'(i_num_channels) > NCH_W'(MAX_CHANNELS)) begin
            nch_eff = NCH_W'(MAX_CHANNELS);
        end else begin
            nch_eff = NCH_W'(i_num_channels);
        end
        fpb_eff = (i_frames_per_bar == '0) ? FPB_W'(1) : i_frames_per_bar;

        // The most negative code maps to full scale, which needs the extra bit.
        ext      = {i_sample[SAMPLE_BITS-1], i_sample};
        mag      = i_sample[SAMPLE_BITS-1] ? (~ext + MAG_W'(1)) : ext;
        sum_wide = {1'b0, r_sums[r_pos]} + (SUM_W+1)'(mag);
        sum_new  = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

        frame_end = (NCH_W'(r_pos) + NCH_W'(1)) >= nch_eff;
        bar_end   = frame_end && (({1'b0, r_frame} + (FPB_W+1)'(1)) >= {1'b0, fpb_eff});
        done      = r_bar >= BC_W'(BAR_COUNT);

        o_sample_ready = done || !bar_end || !i_full;
        accept         = i_sample_valid && o_sample_ready && !done;

        n_sums  = r_sums;
        n_pos   = r_pos;
        n_frame = r_frame;
        n_bar   = r_bar;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            o_push_sums[i] = (POS_W'(i) == r_pos) ? sum_new : r_sums[i];
        end
        if (accept) begin
            n_sums[r_pos] = sum_new;
            if (!frame_end) begin
                n_pos = r_pos + POS_W'(1);
            end else begin
                n_pos = '0;
                if (!bar_end) begin
                    n_frame = r_frame + FPB_W'(1);
                end else begin
                    n_frame = '0;
                    n_bar   = r_bar + BC_W'(1);
                    n_sums  = '0;
                end
            end
        end

        o_push         = accept && bar_end;
        o_push_hdr.fpb = fpb_eff;
        o_push_hdr.nch = nch_eff;
        o_push_hdr.bar = BARIDX_W'(r_bar);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sums  <= '0;
            r_pos   <= '0;
            r_frame <= '0;
            r_bar   <= '0;
        end else begin
            r_sums  <= n_sums;
            r_pos   <= n_pos;
            r_frame <= n_frame;
            r_bar   <= n_bar;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/aeba_queue.sv -----
// Short first-in first-out queue of finished bars between front and back end.
`default_nettype none
module aeba_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = aeba_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_push_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_full     = r_cnt == CNT_W'(DEPTH);
    assign o_valid    = r_cnt != '0;
    assign o_pop_data = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/aeba_back.sv -----
// Back end: divides each channel sum of a bar into a saturated level, one bit a cycle.
`default_nettype none
module aeba_back #(
    parameter int MAX_CHANNELS = aeba_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = aeba_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_job_valid,
    input  logic [MAX_CHANNELS-1:0][aeba_pkg::SUM_W-1:0] i_job_sums,
    input  aeba_pkg::t_bar_hdr                           i_job_hdr,
    output logic                                         o_job_pop,
    output logic                                         o_level_valid,
    input  logic                                         i_level_ready,
    output logic [aeba_pkg::LEVEL_W-1:0]                 o_level,
    output logic [aeba_pkg::CHAN_W-1:0]                  o_channel,
    output logic [aeba_pkg::BARIDX_W-1:0]                o_bar_index,
    output logic                                         o_last
);
    import aeba_pkg::*;

    localparam int POS_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NUM_W  = SUM_W + LEVEL_SHIFT;
    localparam int DSH    = SAMPLE_BITS - 1 + LEVEL_W;
    localparam int DEN_W  = FPB_W + DSH;
    localparam int WW     = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int STEP_W = $clog2(LEVEL_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]          r_state, n_state;
    logic [POS_W-1:0]    r_ch, n_ch;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [WW-1:0]       r_rem, n_rem, r_dsh, n_dsh;
    logic [LEVEL_W-1:0]  r_q, n_q;
    logic                r_sat, n_sat;
    logic                r_ovalid, n_ovalid;
    logic [LEVEL_W-1:0]  r_level, n_level;
    logic [CHAN_W-1:0]   r_chan, n_chan;
    logic [BARIDX_W-1:0] r_baridx, n_baridx;
    logic                r_last, n_last;
    logic                ge, is_last, out_free;

    assign o_level_valid = r_ovalid;
    assign o_level       = r_level;
    assign o_channel     = r_chan;
    assign o_bar_index   = r_baridx;
    assign o_last        = r_last;

    always_comb begin
        ge       = r_rem >= r_dsh;
        is_last  = (NCH_W'(r_ch) + NCH_W'(1)) == i_job_hdr.nch;
        out_free = !r_ovalid || i_level_ready;

        n_state  = r_state;
        n_ch     = r_ch;
        n_step   = r_step;
        n_rem    = r_rem;
        n_dsh    = r_dsh;
        n_q      = r_q;
        n_sat    = r_sat;
        n_ovalid = r_ovalid && !i_level_ready;
        n_level  = r_level;
        n_chan   = r_chan;
        n_baridx = r_baridx;
        n_last   = r_last;
        o_job_pop = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_ch    = '0;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_rem   = WW'({i_job_sums[r_ch], {LEVEL_SHIFT{1'b0}}});
                n_dsh   = WW'(i_job_hdr.fpb) << DSH;
                n_step  = '0;
                n_q     = '0;
                n_sat   = 1'b0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_dsh  = r_dsh >> 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == '0) begin
                    // Quotient would not fit in eight bits: clamp.
                    if (ge) begin
                        n_sat   = 1'b1;
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_q = {r_q[LEVEL_W-2:0], ge};
                    if (ge) begin
                        n_rem = r_rem - r_dsh;
                    end
                    if (r_step == STEP_W'(LEVEL_W)) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_level  = r_sat ? LEVEL_MAX : r_q;
                    n_chan   = CHAN_W'(r_ch);
                    n_baridx = i_job_hdr.bar;
                    n_last   = is_last;
                    if (is_last) begin
                        o_job_pop = 1'b1;
                        n_state   = ST_IDLE;
                    end else begin
                        n_ch    = r_ch + POS_W'(1);
                        n_state = ST_LOAD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ch     <= n_ch;
        r_step   <= n_step;
        r_rem    <= n_rem;
        r_dsh    <= n_dsh;
        r_q      <= n_q;
        r_sat    <= n_sat;
        r_level  <= n_level;
        r_chan   <= n_chan;
        r_baridx <= n_baridx;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/audio_envelope_bar_averager_top.sv -----
// Top level of the audio envelope bar averager: configuration, front, queue and back end.
//
// Usage: interleaved audio samples enter one beat at a time on the sample channel
// (i_sample_valid / o_sample_ready), channel 0 first. Each channel's absolute values
// are summed over frames_per_bar frames. When a bar completes, one beat per channel
// leaves on the level channel (o_level_valid / i_level_ready) carrying the mean
// magnitude over full scale times 512, saturated at 255, plus channel, bar index and a
// last flag on the final channel. After BAR_COUNT bars, samples are taken but ignored.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes num_channels (index 0)
// or frames_per_bar (index 1); it is always ready and should be used while idle.
// Throughput: the front end takes one sample per cycle while it is not stalled. A finished
// bar goes to a two-entry queue; the back end runs each channel through a restoring
// divider (load, nine compare-subtract steps including the clamp check, emit) and
// stops the divide early when the clamp check saturates. It works on one bar at a time,
// channel after channel, and its emit waits out any stall on the level channel.
// The sample that closes a bar pushes it into the queue; an idle back end then picks it
// up, loads, divides and emits its first channel into the output register.
// The front end stalls only when a bar ends while both queue entries are taken.
// Reset (synchronous, active low) clears sums, counters and queue and sets both registers
// to one. A stalled receiver holds the output register; the divider waits, the queue fills.
`default_nettype none
module audio_envelope_bar_averager_top #(
    parameter int MAX_CHANNELS = aeba_pkg::DEF_MAX_CHANNELS,
    parameter int BAR_COUNT    = aeba_pkg::DEF_BAR_COUNT,
    parameter int SAMPLE_BITS  = aeba_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Sample input channel.
    input  logic                                i_sample_valid,
    output logic                                o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    // Level output channel.
    output logic                                o_level_valid,
    input  logic                                i_level_ready,
    output logic [aeba_pkg::LEVEL_W-1:0]        o_level,
    output logic [aeba_pkg::CHAN_W-1:0]         o_channel,
    output logic [aeba_pkg::BARIDX_W-1:0]       o_bar_index,
    output logic                                o_last,
    // Configuration write channel.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [aeba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [aeba_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import aeba_pkg::*;

    localparam int HDR_W = $bits(t_bar_hdr);
    localparam int JOB_W = MAX_CHANNELS * SUM_W + HDR_W;

    // Configuration registers. Writes take effect on the next sample.
    logic [NCH_CFG_W-1:0] r_num_channels;
    logic [FPB_W-1:0]     r_frames_per_bar;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_channels   <= NCH_CFG_W'(1);
            r_frames_per_bar <= FPB_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_CHANNELS:   r_num_channels   <= i_cfg_data[NCH_CFG_W-1:0];
                CFG_FRAMES_PER_BAR: r_frames_per_bar <= i_cfg_data[FPB_W-1:0];
                default: ;
            endcase
        end
    end

    // Front end to queue.
    logic                               q_push, q_full, q_valid, q_pop;
    logic [MAX_CHANNELS-1:0][SUM_W-1:0] push_sums, job_sums;
    t_bar_hdr                           push_hdr, job_hdr;
    logic [JOB_W-1:0]                   job_data;

    aeba_front #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .BAR_COUNT    (BAR_COUNT),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample_valid   (i_sample_valid),
        .o_sample_ready   (o_sample_ready),
        .i_sample         (i_sample),
        .i_num_channels   (r_num_channels),
        .i_frames_per_bar (r_frames_per_bar),
        .i_full           (q_full),
        .o_push           (q_push),
        .o_push_sums      (push_sums),
        .o_push_hdr       (push_hdr)
    );

    // Each queue entry holds a whole bar: every channel sum plus its header.
    aeba_queue #(
        .DATA_W (JOB_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data ({push_sums, push_hdr}),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_pop_data  (job_data)
    );

    assign job_sums = job_data[JOB_W-1:HDR_W];
    assign job_hdr  = job_data[HDR_W-1:0];

    aeba_back #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job_sums    (job_sums),
        .i_job_hdr     (job_hdr),
        .o_job_pop     (q_pop),
        .o_level_valid (o_level_valid),
        .i_level_ready (i_level_ready),
        .o_level       (o_level),
        .o_channel     (o_channel),
        .o_bar_index   (o_bar_index),
        .o_last        (o_last)
    );

    // A finished bar is never offered to a full queue, so no bar is dropped.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("bar pushed into a full queue");

    // The back end only retires a bar that is actually queued.
    a_pop_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // The sample channel is held off only by queue backpressure.
    a_stall_only_on_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_sample_ready |-> q_full)
        else $error("sample channel stalled without a full queue");

    // Retiring a bar coincides with loading its last level into the output register.
    a_pop_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_level_valid && o_last))
        else $error("bar retired without emitting its last level");

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the audio envelope bar averager top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aeba_pkg::*;

    // Run shape. The random part stops once about this many samples are queued.
    localparam int RANDOM_ITEMS  = 290;
    // One-sample bars sent at the end under full pressure on the queue.
    localparam int TAIL_ITEMS    = 12;
    // Cycles to let the front end settle once the last level beat has come.
    localparam int QUIET_CYCLES  = 24;
    // Longest wait for outstanding levels before they are declared missing.
    localparam int DRAIN_LIMIT   = 50000;
    // Hard stop for the whole run, far above the slowest legal run.
    localparam longint RUN_LIMIT_NS = 64'd15_000_000;
    localparam int MAX_REPORTS   = 10;

    // One beat of the level channel, as the predictor expects it.
    typedef struct packed {
        logic [LEVEL_W-1:0]  level;
        logic [CHAN_W-1:0]   chan;
        logic [BARIDX_W-1:0] bar;
        logic                last;
    } level_beat_t;

    // One beat of the configuration channel.
    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    // Block ports. Every input starts at a known value before the first edge.
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_sample_valid = 1'b0;
    logic                  o_sample_ready;
    logic signed [DEF_SAMPLE_BITS-1:0] i_sample = '0;
    logic                  o_level_valid;
    logic                  i_level_ready  = 1'b0;
    logic [LEVEL_W-1:0]    o_level;
    logic [CHAN_W-1:0]     o_channel;
    logic [BARIDX_W-1:0]   o_bar_index;
    logic                  o_last;
    logic                  i_cfg_valid    = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    // Stimulus queues, filled by the initial block and drained by the drivers.
    logic [DEF_SAMPLE_BITS-1:0] sample_feed[$];
    reg_write_t                 reg_writes[$];
    // Levels the predictor has worked out and the block has not yet sent.
    level_beat_t                pending_levels[$];

    int samples_queued = 0;
    int samples_taken  = 0;
    int writes_queued  = 0;
    int writes_done    = 0;
    int mismatches     = 0;

    // Idle shaping, switched per phase so that some stretches run back to back.
    bit gaps_on   = 1'b0;
    bit stalls_on = 1'b0;
    int sample_gap = 0;
    int level_hold = 0;

    // Predictor state: a private copy of the registers and the bar accumulator.
    logic [NCH_CFG_W-1:0] channels_reg = 4'd1;
    logic [FPB_W-1:0]     frames_reg   = 16'd1;
    logic [SUM_W-1:0]     chan_sums[DEF_MAX_CHANNELS] = '{default: '0};
    logic [CHAN_W-1:0]    chan_pos   = '0;
    logic [FPB_W-1:0]     frame_pos  = '0;
    logic [9:0]           bars_done  = '0;

    level_beat_t seen_beat;
    level_beat_t want_beat;

    audio_envelope_bar_averager_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_level_valid  (o_level_valid),
        .i_level_ready  (i_level_ready),
        .o_level        (o_level),
        .o_channel      (o_channel),
        .o_bar_index    (o_bar_index),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // A channel count of zero means one channel, anything above the maximum
    // is clamped to the maximum.
    function automatic int unsigned channels_in_use(input logic [NCH_CFG_W-1:0] field);
        if (field == 0) return 1;
        if (field > DEF_MAX_CHANNELS) return DEF_MAX_CHANNELS;
        return 32'(field);
    endfunction

    // A frame count of zero behaves as a single frame per bar.
    function automatic int unsigned frames_in_use(input logic [FPB_W-1:0] field);
        return (field == 0) ? 32'd1 : 32'(field);
    endfunction

    // Idle length for either side: mostly short, now and then long.
    function automatic int draw_idle(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endtask

    // Adds one accepted sample into the running bar and, when the sample closes
    // a bar, queues one level per active channel. The channel position and frame
    // count survive register writes, so a position at or past the channel count
    // still takes its sample and ends the frame.
    task automatic accumulate_sample(input logic [DEF_SAMPLE_BITS-1:0] smp);
        int unsigned nch;
        int unsigned fpb;
        int unsigned pos;
        logic [SUM_W:0]   total;
        logic [16:0]      mag;
        logic [63:0]      divisor;
        logic [63:0]      quot;
        level_beat_t      beat;
        // Once every bar is done, samples are simply dropped.
        if (bars_done >= DEF_BAR_COUNT) return;
        nch = channels_in_use(channels_reg);
        fpb = frames_in_use(frames_reg);
        pos = 32'(chan_pos);
        // The most negative sample has a magnitude of exactly full scale.
        mag = smp[DEF_SAMPLE_BITS-1] ? 17'h10000 - {1'b0, smp} : {1'b0, smp};
        total = {1'b0, chan_sums[pos]} + mag;
        chan_sums[pos] = total[SUM_W] ? '1 : total[SUM_W-1:0];
        if (pos + 1 < nch) begin
            chan_pos = CHAN_W'(pos + 1);
            return;
        end
        chan_pos = '0;
        if (frame_pos + 1 < fpb) begin
            frame_pos = frame_pos + 1'b1;
            return;
        end
        // Level is sum * 512 / (frames * full scale), truncated, clamped at 255.
        divisor = 64'(fpb) << (DEF_SAMPLE_BITS - 1);
        for (int unsigned c = 0; c < nch; c++) begin
            quot = (64'(chan_sums[c]) << LEVEL_SHIFT) / divisor;
            beat.level = (quot > 64'(LEVEL_MAX)) ? LEVEL_MAX : quot[LEVEL_W-1:0];
            beat.chan  = CHAN_W'(c);
            beat.bar   = bars_done[BARIDX_W-1:0];
            beat.last  = (c + 1 == nch);
            pending_levels = {pending_levels, beat};
        end
        for (int c = 0; c < DEF_MAX_CHANNELS; c++) chan_sums[c] = '0;
        frame_pos = '0;
        bars_done = bars_done + 1'b1;
    endtask

    // Sample driver. Valid goes up with a queued sample and holds with the same
    // payload until the beat is taken; a random gap may follow each beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
            sample_gap     <= 0;
        end else begin
            if (i_sample_valid && o_sample_ready) begin
                accumulate_sample(i_sample);
                samples_taken++;
            end
            if (!i_sample_valid || o_sample_ready) begin
                if (sample_gap != 0) begin
                    sample_gap     <= sample_gap - 1;
                    i_sample_valid <= 1'b0;
                end else if (sample_feed.size() != 0) begin
                    i_sample_valid <= 1'b1;
                    i_sample       <= sample_feed.pop_front();
                    sample_gap     <= draw_idle(gaps_on);
                end else begin
                    i_sample_valid <= 1'b0;
                end
            end
        end
    end

    // Configuration driver. The predictor's register copy changes on the same
    // edge as the block's, and only while no sample is in flight.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_NUM_CHANNELS:   channels_reg = i_cfg_data[NCH_CFG_W-1:0];
                    CFG_FRAMES_PER_BAR: frames_reg   = i_cfg_data[FPB_W-1:0];
                    default: ;
                endcase
                writes_done++;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (reg_writes.size() != 0) begin
                    reg_write_t w;
                    w = reg_writes.pop_front();
                    i_cfg_valid <= 1'b1;
                    i_cfg_index <= w.idx;
                    i_cfg_data  <= w.data;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Level monitor. Each taken beat is checked against the oldest prediction,
    // and ready is dropped for random stretches to back the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_level_ready <= 1'b0;
            level_hold    <= 0;
        end else begin
            if (o_level_valid && i_level_ready) begin
                seen_beat = '{o_level, o_channel, o_bar_index, o_last};
                if (pending_levels.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected level beat: level %0d channel %0d bar %0d last %0b",
                        seen_beat.level, seen_beat.chan, seen_beat.bar, seen_beat.last));
                end else begin
                    want_beat = pending_levels.pop_front();
                    if (seen_beat !== want_beat) begin
                        note_mismatch($sformatf({"level beat mismatch: expected level %0d ",
                            "channel %0d bar %0d last %0b, got level %0d channel %0d ",
                            "bar %0d last %0b"},
                            want_beat.level, want_beat.chan, want_beat.bar, want_beat.last,
                            seen_beat.level, seen_beat.chan, seen_beat.bar, seen_beat.last));
                    end
                end
            end
            if (level_hold != 0) begin
                level_hold    <= level_hold - 1;
                i_level_ready <= 1'b0;
            end else if (stalls_on && $urandom_range(0, 99) < 15) begin
                level_hold    <= draw_idle(1'b1);
                i_level_ready <= 1'b0;
            end else begin
                i_level_ready <= 1'b1;
            end
        end
    end

    // Writes one register and returns once the write beat has been taken.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_writes = {reg_writes, w};
        writes_queued++;
        while (writes_done != writes_queued) @(posedge i_clk);
    endtask

    task automatic queue_sample(input logic [DEF_SAMPLE_BITS-1:0] value);
        sample_feed = {sample_feed, value};
        samples_queued++;
    endtask

    // Random samples: a few extremes, some over the full range, and many of
    // moderate magnitude so that the levels mostly stay below saturation.
    task automatic queue_random(input int count);
        int r;
        int mag;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                case ($urandom_range(0, 3))
                    0: queue_sample(16'h7FFF);
                    1: queue_sample(16'h8000);
                    2: queue_sample(16'h0000);
                    default: queue_sample(16'hFFFF);
                endcase
            end else if (r < 40) begin
                queue_sample(16'($urandom));
            end else begin
                mag = (r < 70) ? $urandom_range(0, 8191) : $urandom_range(0, 16383);
                queue_sample($urandom_range(0, 1) ? 16'(-mag) : 16'(mag));
            end
        end
    endtask

    // Waits until every queued sample is taken and every predicted level has
    // come back, then lets the block go quiet before any register write.
    task automatic settle();
        int waited;
        waited = 0;
        while (samples_taken != samples_queued) @(posedge i_clk);
        while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_levels.size() != 0) begin
            note_mismatch($sformatf("%0d predicted level beats never arrived",
                                    pending_levels.size()));
            pending_levels.delete();
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Main sequence: directed corners first, then random phases with fresh
    // register settings, then a short burst of single-sample bars.
    initial begin
        int random_items;
        int nsel;
        int fsel;
        logic [NCH_CFG_W-1:0] nch_field;
        logic [FPB_W-1:0]     fpb_field;
        int unsigned per_bar;
        int count;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: one channel, one frame, so each sample is a bar.
        // Covers both full-scale ends, zero, tiny values and the clamp knee.
        queue_sample(16'h7FFF);
        queue_sample(16'h8000);
        queue_sample(16'h0000);
        queue_sample(16'hFFFF);
        queue_sample(16'd64);
        queue_sample(-16'sd129);
        queue_sample(16'd16383);
        queue_sample(16'd16384);
        settle();

        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // A channel count of zero, with the unused upper data bits set.
        write_reg(CFG_NUM_CHANNELS, 16'hFFF0);
        queue_sample(16'h8000);
        settle();

        // A channel count above the maximum is clamped to eight channels.
        write_reg(CFG_NUM_CHANNELS, 16'h000F);
        queue_random(8);
        settle();

        // Zero frames per bar, and a channel count cut while a frame is half
        // done: the next sample lands past the new count and closes the bar.
        write_reg(CFG_FRAMES_PER_BAR, 16'h0000);
        write_reg(CFG_NUM_CHANNELS, 16'd4);
        queue_random(3);
        settle();
        write_reg(CFG_NUM_CHANNELS, 16'd2);
        queue_random(1);
        settle();

        // Largest frame count, then lowered to no more than the frames already summed:
        // the bar ends at the next frame end.
        write_reg(CFG_FRAMES_PER_BAR, 16'hFFFF);
        queue_random(2);
        settle();
        write_reg(CFG_FRAMES_PER_BAR, 16'd1);
        queue_random(2);
        settle();

        // Random phases. Mostly whole bars; sometimes a partial bar is left
        // behind so the next register write lands mid-bar.
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            nsel = $urandom_range(0, 9);
            if (nsel == 0)      nch_field = 4'd0;
            else if (nsel == 1) nch_field = 4'($urandom_range(9, 15));
            else                nch_field = 4'($urandom_range(1, 8));
            fsel = $urandom_range(0, 19);
            if (fsel == 0)      fpb_field = 16'd0;
            else if (fsel < 13) fpb_field = 16'($urandom_range(1, 4));
            else if (fsel < 18) fpb_field = 16'($urandom_range(5, 16));
            else                fpb_field = 16'($urandom_range(17, 40));
            if (channels_in_use(nch_field) * frames_in_use(fpb_field) > 96)
                fpb_field = 16'($urandom_range(1, 4));
            per_bar = channels_in_use(nch_field) * frames_in_use(fpb_field);
            write_reg(CFG_NUM_CHANNELS, {12'($urandom), nch_field});
            write_reg(CFG_FRAMES_PER_BAR, fpb_field);
            count = (per_bar > 48) ? per_bar : per_bar * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(0, per_bar - 1);
            queue_random(count);
            random_items += count;
            settle();
        end

        // Finish with back-to-back one-sample bars and full pressure on the
        // queue, so the front end has to wait on a full queue.
        gaps_on   = 1'b0;
        stalls_on = 1'b1;
        write_reg(CFG_NUM_CHANNELS, {12'($urandom), 4'd1});
        write_reg(CFG_FRAMES_PER_BAR, 16'd1);
        queue_random(TAIL_ITEMS);
        settle();

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a block that hangs on either channel.
    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
